// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define CUAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clk edge, reset included.
`define CUAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/cuat_pkg.sv -----
package cuat_pkg;

  localparam int ID_W   = 64;
  localparam int SLOT_W = 7;

  // Operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [ID_W-1:0] card_id;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] removed_count;
    logic [1:0]        status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_ADD,
    S_DONE
  } state_t;

endpackage

// ----- rtl/cuat_chan_if.sv -----
interface cuat_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/cuat_mem.sv -----
module cuat_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 65
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port: one read or one write per cycle, registered read data
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/cuat_ctrl.sv -----
`include "assert_macros.svh"

module cuat_ctrl #(
  parameter int TABLE_SLOTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  cuat_pkg::req_t                 start_req,
  input  logic                           out_free,
  output logic                           idle,
  output logic                           done,
  output cuat_pkg::rsp_t                 result,
  output logic                           mem_en,
  output logic                           mem_we,
  output logic [$clog2(TABLE_SLOTS)-1:0] mem_addr,
  output logic [cuat_pkg::ID_W:0]        mem_wdata,
  input  logic [cuat_pkg::ID_W:0]        mem_rdata
);

  localparam int IW = $clog2(TABLE_SLOTS);
  localparam int CW = $clog2(TABLE_SLOTS + 1);
  localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

  cuat_pkg::state_t state, state_next;
  logic [IW-1:0] idx, idx_next;

  // Request and scan accumulators
  logic [1:0]                op;
  logic [cuat_pkg::ID_W-1:0] id;
  logic                      hit;
  logic [IW-1:0]             hit_idx;
  logic                      free_ok;
  logic [IW-1:0]             free_idx;
  logic [CW-1:0]             cnt;

  logic    entry_v;
  logic    entry_match;
  logic    kill;
  logic [IW:0] slot_wide;

  assign entry_v     = mem_rdata[cuat_pkg::ID_W];
  assign entry_match = entry_v && (mem_rdata[cuat_pkg::ID_W-1:0] == id);
  assign kill        = ((op == cuat_pkg::OP_DELETE) && entry_match) ||
                       ((op == cuat_pkg::OP_CLEAR) && entry_v);

  // State and index registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cuat_pkg::S_INIT;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // Next state and memory port
  always_comb begin
    state_next = state;
    idx_next   = idx;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = idx;
    mem_wdata  = {1'b0, mem_rdata[cuat_pkg::ID_W-1:0]};
    idle       = 1'b0;
    done       = 1'b0;
    case (state)
      cuat_pkg::S_INIT: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = cuat_pkg::S_IDLE;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      cuat_pkg::S_IDLE: begin
        idle     = 1'b1;
        idx_next = '0;
        if (start) begin
          state_next = cuat_pkg::S_READ;
        end
      end
      cuat_pkg::S_READ: begin
        mem_en     = 1'b1;
        state_next = cuat_pkg::S_CHECK;
      end
      cuat_pkg::S_CHECK: begin
        mem_en = kill;
        mem_we = kill;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = (op == cuat_pkg::OP_ADD) ? cuat_pkg::S_ADD : cuat_pkg::S_DONE;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = cuat_pkg::S_READ;
        end
      end
      cuat_pkg::S_ADD: begin
        mem_addr   = free_idx;
        mem_wdata  = {1'b1, id};
        mem_en     = !hit && free_ok;
        mem_we     = !hit && free_ok;
        state_next = cuat_pkg::S_DONE;
      end
      cuat_pkg::S_DONE: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = cuat_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cuat_pkg::S_IDLE;
      end
    endcase
  end

  // Scan accumulators
  always_ff @(posedge clk) begin
    if (state == cuat_pkg::S_IDLE && start) begin
      op      <= start_req.opcode;
      id      <= start_req.card_id;
      hit     <= 1'b0;
      free_ok <= 1'b0;
      cnt     <= '0;
    end else if (state == cuat_pkg::S_CHECK) begin
      if (entry_match && !hit) begin
        hit     <= 1'b1;
        hit_idx <= idx;
      end
      if (!entry_v && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= idx;
      end
      if (kill) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  // Result fields
  always_comb begin
    result.found         = hit;
    result.removed_count = cuat_pkg::SLOT_W'(cnt);
    result.status        = cuat_pkg::ST_OK;
    slot_wide            = '0;
    case (op)
      cuat_pkg::OP_LOOKUP, cuat_pkg::OP_DELETE: begin
        if (hit) begin
          slot_wide = {1'b0, hit_idx} + (IW + 1)'(1);
        end
      end
      cuat_pkg::OP_ADD: begin
        if (hit) begin
          slot_wide     = {1'b0, hit_idx} + (IW + 1)'(1);
          result.status = cuat_pkg::ST_PRESENT;
        end else if (free_ok) begin
          slot_wide = {1'b0, free_idx} + (IW + 1)'(1);
        end else begin
          result.status = cuat_pkg::ST_FULL;
        end
      end
      default: begin
        slot_wide = '0;
      end
    endcase
    result.slot = cuat_pkg::SLOT_W'(slot_wide);
  end

  `CUAT_ASSERT(a_no_write_idle, (state == cuat_pkg::S_IDLE) |-> !mem_we, "write while idle")
  `CUAT_ASSERT(a_done_free, done |-> out_free, "result produced into a full output register")
  `CUAT_ASSERT(a_add_write, (state == cuat_pkg::S_ADD && mem_we) |-> (!hit && free_ok), "add wrote over present or full table")
  `CUAT_ASSERT(a_cnt_bound, (state == cuat_pkg::S_DONE) |-> (cnt <= CW'(TABLE_SLOTS)), "removed count beyond table size")

endmodule

// ----- rtl/card_uid_allowlist_table_top.sv -----
// Card identifier allow-list: a set of TABLE_SLOTS 64-bit identifiers.
// req channel (sink): opcode and card_id; opcode selects lookup, add, delete
// of all matches, or clear. rsp channel (source): found, slot (index plus
// one, 0 for none), removed_count and status, one response per request.
// A request is taken only while the block is idle. Each request scans every
// slot of a single-port memory holding {valid, id}, slot by slot (read,
// then check and optional write-back); for add, an add step then writes the
// identifier to the first free slot if it is absent. The block is idle again
// once the response is in the output register, so it takes no new request
// before it is through with the last one, but does take one even if the
// receiver has not yet taken the response.
// After reset the block sweeps the memory clearing every entry, one per
// cycle, and accepts no request during the sweep.
// If the receiver stalls, the response holds in the output register and a
// following request finishes its scan, then waits until that register frees.
`include "assert_macros.svh"

module card_uid_allowlist_table_top #(
  parameter int TABLE_SLOTS = 64
) (
  input logic         clk,
  input logic         rst,
  cuat_chan_if.sink   req,
  cuat_chan_if.source rsp
);

  logic                           ctrl_idle;
  logic                           ctrl_done;
  logic                           out_free;
  cuat_pkg::rsp_t                 ctrl_result;
  logic                           mem_en;
  logic                           mem_we;
  logic [$clog2(TABLE_SLOTS)-1:0] mem_addr;
  logic [cuat_pkg::ID_W:0]        mem_wdata;
  logic [cuat_pkg::ID_W:0]        mem_rdata;
  logic                           rsp_valid;
  cuat_pkg::rsp_t                 rsp_data;
  logic                           req_fire;

  assign req.ready = ctrl_idle;
  assign req_fire  = req.valid && ctrl_idle;
  assign out_free  = !rsp_valid || rsp.ready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl_done) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_done) begin
      rsp_data <= ctrl_result;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  cuat_ctrl #(.TABLE_SLOTS(TABLE_SLOTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (req_fire),
    .start_req (req.data),
    .out_free  (out_free),
    .idle      (ctrl_idle),
    .done      (ctrl_done),
    .result    (ctrl_result),
    .mem_en    (mem_en),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  cuat_mem #(.DEPTH(TABLE_SLOTS), .WIDTH(cuat_pkg::ID_W + 1)) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  `CUAT_ASSERT(a_busy_after_req, req_fire |=> !req.ready, "second request taken during a scan")
  `CUAT_ASSERT(a_done_not_idle, ctrl_done |-> !ctrl_idle, "response produced while idle")
  `CUAT_ASSERT_ALWAYS(a_reset_quiet, rst |=> !rsp_valid, "response pending right after reset")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

// Tracks the allow-list contents and the responses still owed by the block
class allowlist_scoreboard;
  localparam int SLOTS = 64;

  logic [cuat_pkg::ID_W-1:0] ids [SLOTS];
  bit                        in_use [SLOTS];
  cuat_pkg::rsp_t            owed_q [$];
  int                        mismatches;

  function new();
    mismatches = 0;
    foreach (in_use[i]) in_use[i] = 1'b0;
  endfunction

  // Applies one request to the table copy and returns the response it earns
  function cuat_pkg::rsp_t apply_request(cuat_pkg::req_t r);
    cuat_pkg::rsp_t res;
    int   hit;
    int   hole;
    res = '0;
    hit = -1;
    hole = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (in_use[i] && ids[i] == r.card_id) hit = i;
      if (!in_use[i]) hole = i;
    end
    res.found = (hit >= 0);
    res.status = cuat_pkg::ST_OK;
    case (r.opcode)
      cuat_pkg::OP_LOOKUP: begin
        if (hit >= 0) res.slot = cuat_pkg::SLOT_W'(hit + 1);
      end
      cuat_pkg::OP_ADD: begin
        if (hit >= 0) begin
          res.slot = cuat_pkg::SLOT_W'(hit + 1);
          res.status = cuat_pkg::ST_PRESENT;
        end else if (hole >= 0) begin
          ids[hole] = r.card_id;
          in_use[hole] = 1'b1;
          res.slot = cuat_pkg::SLOT_W'(hole + 1);
        end else begin
          res.status = cuat_pkg::ST_FULL;
        end
      end
      cuat_pkg::OP_DELETE: begin
        if (hit >= 0) res.slot = cuat_pkg::SLOT_W'(hit + 1);
        for (int i = 0; i < SLOTS; i++) begin
          if (in_use[i] && ids[i] == r.card_id) begin
            in_use[i] = 1'b0;
            res.removed_count = res.removed_count + 1'b1;
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (in_use[i]) begin
            in_use[i] = 1'b0;
            res.removed_count = res.removed_count + 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  function void note_request(cuat_pkg::req_t r);
    owed_q.push_back(apply_request(r));
  endfunction

  function void check_response(cuat_pkg::rsp_t got);
    cuat_pkg::rsp_t want;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected response: found=%0d slot=%0d removed=%0d status=%0d",
                 got.found, got.slot, got.removed_count, got.status);
      return;
    end
    want = owed_q.pop_front();
    if (got.found != want.found || got.slot != want.slot ||
        got.removed_count != want.removed_count || got.status != want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("response mismatch: expected found=%0d slot=%0d removed=%0d status=%0d, %s",
                 want.found, want.slot, want.removed_count, want.status,
                 $sformatf("got found=%0d slot=%0d removed=%0d status=%0d",
                           got.found, got.slot, got.removed_count, got.status));
    end
  endfunction

  function int outstanding();
    return owed_q.size();
  endfunction
endclass

module tb_top;
  localparam int  TABLE_SLOTS = 64;
  localparam int  TOTAL_REQS  = 1350;
  localparam int  POOL_SIZE   = 72;
  localparam logic [cuat_pkg::ID_W-1:0] SPACES = 64'h2020_2020_2020_2020;
  localparam logic [cuat_pkg::ID_W-1:0] ONES   = '1;
  localparam logic [cuat_pkg::ID_W-1:0] TEXT_ID = 64'h4142_4344_3132_3334;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   calm = 1'b0;
  int   stall_left = 0;

  allowlist_scoreboard board = new();

  cuat_chan_if #(.payload_t(cuat_pkg::req_t)) req_ch ();
  cuat_chan_if #(.payload_t(cuat_pkg::rsp_t)) rsp_ch ();

  card_uid_allowlist_table_top #(.TABLE_SLOTS(TABLE_SLOTS)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #40_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Record accepted requests
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) board.note_request(req_ch.data);
  end

  // Check accepted responses
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) board.check_response(rsp_ch.data);
  end

  // Receiver back-pressure: mostly short stalls, now and then one longer than a scan
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      rsp_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(999) < 2) begin
      stall_left <= ($urandom_range(4) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] op, input logic [cuat_pkg::ID_W-1:0] id);
    cuat_pkg::req_t item;
    item.opcode = op;
    item.card_id = id;
    if (!calm && $urandom_range(99) < 7) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 150)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= item;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  initial begin
    logic [cuat_pkg::ID_W-1:0] pool [POOL_SIZE];
    logic [cuat_pkg::ID_W-1:0] id;
    logic [1:0]      op;
    logic [7:0]      ch;
    int              roll;
    int              mode;
    int              sent;

    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, edge identifiers, refusals, holes and clear counts
    send_request(cuat_pkg::OP_LOOKUP, '0);
    send_request(cuat_pkg::OP_DELETE, '0);
    send_request(cuat_pkg::OP_CLEAR, ONES);
    send_request(cuat_pkg::OP_ADD, '0);
    send_request(cuat_pkg::OP_ADD, ONES);
    send_request(cuat_pkg::OP_ADD, SPACES);
    send_request(cuat_pkg::OP_ADD, SPACES);
    send_request(cuat_pkg::OP_LOOKUP, SPACES);
    send_request(cuat_pkg::OP_LOOKUP, '0);
    send_request(cuat_pkg::OP_LOOKUP, TEXT_ID);
    send_request(cuat_pkg::OP_DELETE, ONES);
    send_request(cuat_pkg::OP_ADD, TEXT_ID);
    send_request(cuat_pkg::OP_DELETE, ONES);
    send_request(cuat_pkg::OP_ADD, ONES);
    send_request(cuat_pkg::OP_CLEAR, SPACES);
    send_request(cuat_pkg::OP_LOOKUP, SPACES);
    send_request(cuat_pkg::OP_ADD, 64'h8000_0000_0000_0001);
    send_request(cuat_pkg::OP_ADD, 64'h7FFF_FFFF_FFFF_FFFE);
    send_request(cuat_pkg::OP_CLEAR, '0);
    sent = 19;

    // Identifier pool a little larger than the table so it fills and overflows
    pool[0] = '0;
    pool[1] = ONES;
    pool[2] = SPACES;
    pool[3] = TEXT_ID;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i % 3 == 0) begin
        pool[i] = {$urandom, $urandom};
      end else begin
        for (int b = 0; b < 8; b++) begin
          roll = $urandom_range(15);
          ch = (roll < 10) ? 8'h30 + roll[7:0] : 8'h37 + roll[7:0];
          pool[i][b*8 +: 8] = ch;
        end
      end
    end

    // Random: fill-heavy, mixed and drain-heavy segments in turn
    for (int n = 0; sent < TOTAL_REQS; n++) begin
      calm = (n >= 400 && n < 700);
      mode = (n / 150) % 3;
      roll = $urandom_range(99);
      case (mode)
        0: op = (roll < 85) ? cuat_pkg::OP_ADD : (roll < 95) ? cuat_pkg::OP_LOOKUP :
                cuat_pkg::OP_DELETE;
        1: op = (roll < 35) ? cuat_pkg::OP_LOOKUP : (roll < 65) ? cuat_pkg::OP_ADD :
                (roll < 96) ? cuat_pkg::OP_DELETE : cuat_pkg::OP_CLEAR;
        default: op = (roll < 50) ? cuat_pkg::OP_DELETE : (roll < 80) ? cuat_pkg::OP_LOOKUP :
                      (roll < 95) ? cuat_pkg::OP_ADD : cuat_pkg::OP_CLEAR;
      endcase
      id = ($urandom_range(99) < 80) ? pool[$urandom_range(POOL_SIZE - 1)] :
           {$urandom, $urandom};
      send_request(op, id);
      sent++;
    end
    calm = 1'b0;
    req_ch.valid <= 1'b0;

    // Drain outstanding responses, then allow for a stray one
    while (board.outstanding() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
